// File: rtl/core/dqt_pkg.sv
// dqt_pkg: shared types and constants for the delimited quoted tokenizer
// used by dqt_classify and delimited_quoted_tokenizer; no dependencies
`default_nettype none

package dqt_pkg;

   localparam int DQT_LENGTH_BITS = 16;
   localparam int DELIM_SLOTS     = 6;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 8;

   // character codes
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_NUL    = 8'h00;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_DELIM_COUNT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DELIM_A     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DELIM_B     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DELIM_C     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DELIM_D     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DELIM_E     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DELIM_F     = 3'd6;

   // reset values of the registers
   localparam logic [2:0] RST_DELIM_COUNT = 3'd4;
   localparam logic [7:0] RST_DELIM_A     = 8'd32;
   localparam logic [7:0] RST_DELIM_B     = 8'd9;
   localparam logic [7:0] RST_DELIM_C     = 8'd13;
   localparam logic [7:0] RST_DELIM_D     = 8'd10;
   localparam logic [7:0] RST_DELIM_E     = 8'd0;
   localparam logic [7:0] RST_DELIM_F     = 8'd0;

   typedef struct packed {
      logic [2:0]                   delim_count;
      logic [DELIM_SLOTS-1:0][7:0]  delim;
   } dqt_cfg_type;

   typedef struct packed {
      logic [7:0]  char_out;
      logic        is_content;
      logic        token_begins;
      logic        token_done;
      logic        was_quoted;
      logic [15:0] token_length;
   } dqt_result_type;

endpackage

`default_nettype wire

// File: rtl/core/dqt_classify.sv
// dqt_classify: per-byte tokenizer state machine and result logic
// depends on dqt_pkg
`default_nettype none

module dqt_classify #(
   parameter int LENGTH_BITS = dqt_pkg::DQT_LENGTH_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire dqt_pkg::dqt_cfg_type    cfg,
   input  wire logic                    step,
   input  wire logic [7:0]              char_in,
   input  wire logic                    last,
   output dqt_pkg::dqt_result_type      result
);
   import dqt_pkg::*;

   localparam logic [1:0] MODE_SKIP   = 2'd0;
   localparam logic [1:0] MODE_PLAIN  = 2'd1;
   localparam logic [1:0] MODE_QUOTED = 2'd2;

   logic [1:0]             mode_ff, mode_in;
   logic                   esc_ff, esc_in;
   logic                   quoted_ff, quoted_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in, count_base;

   logic                   is_zero, char_delim, lf_delim;
   logic                   content, begins, done, active;
   logic [LENGTH_BITS+15:0] length_ext;

   // slot i is live when delim_count > i; a count of seven acts as six
   always_comb begin
      char_delim = 1'b0;
      lf_delim   = 1'b0;
      for (int i = 0; i < DELIM_SLOTS; i++) begin
         if (cfg.delim_count > 3'(i)) begin
            if (cfg.delim[i] == char_in) char_delim = 1'b1;
            if (cfg.delim[i] == CH_LF)   lf_delim   = 1'b1;
         end
      end
   end

   assign is_zero = (char_in == CH_NUL);

   always_comb begin
      content    = 1'b0;
      begins     = 1'b0;
      done       = 1'b0;
      active     = 1'b0;
      mode_in    = mode_ff;
      esc_in     = esc_ff;
      quoted_in  = quoted_ff;
      count_base = count_ff;
      unique case (mode_ff)
         MODE_SKIP: begin
            if (!is_zero && !char_delim) begin
               begins     = 1'b1;
               active     = 1'b1;
               esc_in     = 1'b0;
               count_base = '0;
               done       = last;
               if (char_in == CH_QUOTE) begin
                  quoted_in = 1'b1;
                  mode_in   = MODE_QUOTED;
               end else begin
                  quoted_in = 1'b0;
                  mode_in   = MODE_PLAIN;
                  content   = 1'b1;
               end
            end
         end
         MODE_PLAIN: begin
            active = 1'b1;
            if (is_zero || char_delim) begin
               done = 1'b1;
            end else begin
               content = 1'b1;
               done    = last;
            end
         end
         MODE_QUOTED: begin
            active = 1'b1;
            // a newline ends a quoted token even when escaped, if LF is a live delimiter
            if (is_zero || (char_in == CH_LF && lf_delim)) begin
               done = 1'b1;
            end else if (esc_ff) begin
               esc_in  = 1'b0;
               content = 1'b1;
            end else if (char_in == CH_BSLASH) begin
               esc_in  = 1'b1;
               content = 1'b1;
            end else if (char_in == CH_QUOTE) begin
               done = 1'b1;
            end else begin
               content = 1'b1;
            end
            if (last) done = 1'b1;
         end
         default: begin
         end
      endcase

      // saturating content count
      count_in = count_base;
      if (content && !(&count_base)) count_in = count_base + 1'b1;

      if (done || (mode_ff != MODE_SKIP && mode_ff != MODE_PLAIN &&
                   mode_ff != MODE_QUOTED)) begin
         mode_in = MODE_SKIP;
         esc_in  = 1'b0;
      end
   end

   assign length_ext = {16'b0, count_in};

   always_comb begin
      result.char_out     = char_in;
      result.is_content   = content;
      result.token_begins = begins;
      result.token_done   = done;
      result.was_quoted   = active & quoted_in;
      result.token_length = active ? length_ext[15:0] : 16'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_SKIP;
         esc_ff    <= 1'b0;
         quoted_ff <= 1'b0;
         count_ff  <= '0;
      end else if (step) begin
         mode_ff   <= mode_in;
         esc_ff    <= esc_in;
         quoted_ff <= quoted_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_done_returns_to_skip: assert property (@(posedge clock) disable iff (reset)
      step && result.token_done |=> mode_ff == MODE_SKIP)
      else $error("token end did not return to skipping");

   a_begin_opens_token: assert property (@(posedge clock) disable iff (reset)
      step && result.token_begins && !result.token_done |=> mode_ff != MODE_SKIP)
      else $error("token start did not open a token");

   a_escape_only_quoted: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> mode_ff == MODE_QUOTED)
      else $error("escape pending outside a quoted token");

   a_content_counts: assert property (@(posedge clock) disable iff (reset)
      step && result.is_content |=> count_ff != '0)
      else $error("content byte left the count at zero");
`endif

endmodule

`default_nettype wire

// File: rtl/core/delimited_quoted_tokenizer.sv
// delimited_quoted_tokenizer: top level with register file, classifier and output skid
// depends on dqt_pkg and dqt_classify
`default_nettype none

// One byte is accepted per clock while req_stall is low, and one result comes back per
// byte, registered in the output register before it appears on rsp_. The tokenizer
// state updates in a single register stage, so back-to-back bytes stream at full rate;
// an output register plus a one-entry skid buffer keep req_stall a registered signal.
// A transfer that arrives while the output register is full and rsp_stall is high is
// parked in the skid entry, and req_stall is then high from the next cycle until the
// parked result has moved into the output register. The user must write delimiter
// registers through the csr_ port only while no byte is in flight; it is not enforced.

module delimited_quoted_tokenizer #(
   parameter int LENGTH_BITS = dqt_pkg::DQT_LENGTH_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write,
   input  wire logic [dqt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [dqt_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic [7:0]                           req_char_in,
   input  wire logic                                 req_last,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic [7:0]                           rsp_char_out,
   output      logic                                 rsp_is_content,
   output      logic                                 rsp_token_begins,
   output      logic                                 rsp_token_done,
   output      logic                                 rsp_was_quoted,
   output      logic [15:0]                          rsp_token_length
);
   import dqt_pkg::*;

   dqt_cfg_type    cfg_ff;
   dqt_result_type new_result;
   dqt_result_type out_ff, skid_ff;
   logic           out_valid_ff, skid_valid_ff;
   logic           req_take, rsp_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delim_count <= RST_DELIM_COUNT;
         cfg_ff.delim[0]    <= RST_DELIM_A;
         cfg_ff.delim[1]    <= RST_DELIM_B;
         cfg_ff.delim[2]    <= RST_DELIM_C;
         cfg_ff.delim[3]    <= RST_DELIM_D;
         cfg_ff.delim[4]    <= RST_DELIM_E;
         cfg_ff.delim[5]    <= RST_DELIM_F;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_DELIM_COUNT: cfg_ff.delim_count <= csr_wdata[2:0];
            REG_DELIM_A:     cfg_ff.delim[0]    <= csr_wdata;
            REG_DELIM_B:     cfg_ff.delim[1]    <= csr_wdata;
            REG_DELIM_C:     cfg_ff.delim[2]    <= csr_wdata;
            REG_DELIM_D:     cfg_ff.delim[3]    <= csr_wdata;
            REG_DELIM_E:     cfg_ff.delim[4]    <= csr_wdata;
            REG_DELIM_F:     cfg_ff.delim[5]    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid & ~skid_valid_ff;
   assign rsp_take  = out_valid_ff & ~rsp_stall;

   dqt_classify #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_classify (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .step    (req_take),
      .char_in (req_char_in),
      .last    (req_last),
      .result  (new_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_take) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_take;
         end
      end else if (req_take) begin
         // output register busy: park the new result in the skid entry
         if (out_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (req_take) begin
            out_ff <= new_result;
         end
      end else if (req_take) begin
         if (out_valid_ff) begin
            skid_ff <= new_result;
         end else begin
            out_ff <= new_result;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_char_out     = out_ff.char_out;
   assign rsp_is_content   = out_ff.is_content;
   assign rsp_token_begins = out_ff.token_begins;
   assign rsp_token_done   = out_ff.token_done;
   assign rsp_was_quoted   = out_ff.was_quoted;
   assign rsp_token_length = out_ff.token_length;

`ifndef SYNTHESIS
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_blocked_transfer_parks: assert property (@(posedge clock) disable iff (reset)
      req_take && out_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("transfer into a blocked output was not parked");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_stall |=> !skid_valid_ff)
      else $error("skid entry did not drain");
`endif

endmodule

`default_nettype wire

// File: tb/delimited_quoted_tokenizer_test.sv
// delimited_quoted_tokenizer_test: self-checking bench for the delimited quoted tokenizer
// streams directed and random text through several delimiter settings and checks each
// result in order against a predictor; depends on dqt_pkg and delimited_quoted_tokenizer
module delimited_quoted_tokenizer_test;
   import dqt_pkg::*;

   localparam int RUN_LIMIT = 3_000_000;
   localparam int LONG_TOKEN = 120;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NONE = 3'd7;
   localparam longint unsigned LENGTH_MAX = (64'd1 << DQT_LENGTH_BITS) - 1;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   typedef enum logic [1:0] {SKIPPING, IN_PLAIN, IN_QUOTED} scan_type;

   typedef struct {
      logic [7:0] ch;
      logic       last;
      bit         no_gap;
   } text_byte_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_char_in = '0;
   logic                      req_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [7:0]                rsp_char_out;
   logic                      rsp_is_content;
   logic                      rsp_token_begins;
   logic                      rsp_token_done;
   logic                      rsp_was_quoted;
   logic [15:0]               rsp_token_length;

   // predictor copy of the registers and the tokenizer state
   logic [2:0] delim_count_q = RST_DELIM_COUNT;
   logic [7:0] delim_set [DELIM_SLOTS] = '{RST_DELIM_A, RST_DELIM_B, RST_DELIM_C,
                                           RST_DELIM_D, RST_DELIM_E, RST_DELIM_F};
   scan_type        scan_mode = SKIPPING;
   logic            escape_pending = 1'b0;
   longint unsigned content_count = 0;
   logic            quoted_flag = 1'b0;

   text_byte_type  text_queue [$];
   dqt_result_type expected_results [$];
   int pushed_total = 0;
   int checked_total = 0;
   int mismatch_count = 0;
   int drv_gap = 0;
   int drv_calm = 0;
   int mon_hold = 0;
   int mon_calm = 0;

   delimited_quoted_tokenizer u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_in      (req_char_in),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_char_out     (rsp_char_out),
      .rsp_is_content   (rsp_is_content),
      .rsp_token_begins (rsp_token_begins),
      .rsp_token_done   (rsp_token_done),
      .rsp_was_quoted   (rsp_was_quoted),
      .rsp_token_length (rsp_token_length)
   );

   always #5 clock = ~clock;

   function automatic bit is_delim(input logic [7:0] c);
      int n;
      int i;
      n = (delim_count_q > 3'd6) ? DELIM_SLOTS : int'(delim_count_q);
      for (i = 0; i < n; i++) begin
         if (delim_set[i] == c) return 1'b1;
      end
      return 1'b0;
   endfunction

   // classify one byte and advance the tokenizer state
   function automatic dqt_result_type tokenize(input logic [7:0] c, input logic fin);
      dqt_result_type r;
      logic content;
      logic begins;
      logic done;
      logic active;
      content = 1'b0;
      begins = 1'b0;
      done = 1'b0;
      active = 1'b0;
      case (scan_mode)
         SKIPPING: begin
            if (c != CH_NUL && !is_delim(c)) begin
               begins = 1'b1;
               active = 1'b1;
               escape_pending = 1'b0;
               content_count = 0;
               if (c == CH_QUOTE) begin
                  quoted_flag = 1'b1;
                  scan_mode = IN_QUOTED;
               end else begin
                  quoted_flag = 1'b0;
                  scan_mode = IN_PLAIN;
                  content = 1'b1;
               end
               done = fin;
            end
         end
         IN_PLAIN: begin
            active = 1'b1;
            if (c == CH_NUL || is_delim(c)) begin
               done = 1'b1;
            end else begin
               content = 1'b1;
               done = fin;
            end
         end
         default: begin
            active = 1'b1;
            // an LF closes a quoted token whenever LF is a delimiter, escaped or not
            if (c == CH_NUL || (c == CH_LF && is_delim(CH_LF))) begin
               done = 1'b1;
            end else if (escape_pending) begin
               escape_pending = 1'b0;
               content = 1'b1;
            end else if (c == CH_BSLASH) begin
               escape_pending = 1'b1;
               content = 1'b1;
            end else if (c == CH_QUOTE) begin
               done = 1'b1;
            end else begin
               content = 1'b1;
            end
            if (fin) done = 1'b1;
         end
      endcase
      if (content && content_count < LENGTH_MAX) content_count++;
      r.char_out     = c;
      r.is_content   = content;
      r.token_begins = begins;
      r.token_done   = done;
      r.was_quoted   = active ? quoted_flag : 1'b0;
      r.token_length = active ? content_count[15:0] : 16'd0;
      if (done) begin
         scan_mode = SKIPPING;
         escape_pending = 1'b0;
      end
      return r;
   endfunction

   // driver: one byte per transfer, random gaps between transfers
   always @(posedge clock) begin : driver
      text_byte_type nb;
      int r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_results.push_back(tokenize(req_char_in, req_last));
         if (!req_valid || !req_stall) begin
            if (drv_gap > 0) begin
               drv_gap--;
               req_valid <= 1'b0;
            end else if (text_queue.size() != 0) begin
               nb = text_queue.pop_front();
               req_valid <= 1'b1;
               req_char_in <= nb.ch;
               req_last <= nb.last;
               if (nb.no_gap) begin
                  drv_gap = 0;
               end else if (drv_calm > 0) begin
                  drv_calm--;
                  drv_gap = 0;
               end else begin
                  r = $urandom_range(0, 99);
                  if (r < 2) drv_calm = $urandom_range(20, 120);
                  drv_gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(4, 20);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result transfer and throttles the result side
   always @(posedge clock) begin : monitor
      dqt_result_type got;
      dqt_result_type want;
      int r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_char_out, rsp_is_content, rsp_token_begins, rsp_token_done,
                   rsp_was_quoted, rsp_token_length};
            checked_total++;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result with nothing expected: char %h", rsp_char_out);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $write("mismatch at result %0d: char %h/%h content %b/%b begins %b/%b",
                            checked_total, want.char_out, got.char_out,
                            want.is_content, got.is_content,
                            want.token_begins, got.token_begins);
                     $display(" done %b/%b quoted %b/%b len %0d/%0d",
                              want.token_done, got.token_done,
                              want.was_quoted, got.was_quoted,
                              want.token_length, got.token_length);
                  end
               end
            end
         end
         if (mon_calm > 0) begin
            mon_calm--;
            rsp_stall <= 1'b0;
         end else if (mon_hold > 0) begin
            mon_hold--;
            rsp_stall <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               mon_calm = $urandom_range(30, 150);
               rsp_stall <= 1'b0;
            end else if (r < 28) begin
               mon_hold = (r < 24) ? $urandom_range(0, 2) : $urandom_range(3, 19);
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   task automatic push(input logic [7:0] c, input logic fin = 1'b0);
      text_queue.push_back('{ch: c, last: fin, no_gap: 1'b0});
      pushed_total++;
   endtask

   task automatic push_string(input string s);
      int i;
      for (i = 0; i < s.len(); i++) push(s[i]);
   endtask

   // one long plain token streamed with no gaps on the input side
   task automatic push_long_token();
      int i;
      for (i = 0; i < LONG_TOKEN; i++) begin
         text_queue.push_back('{ch: 8'($urandom_range(8'h61, 8'h7A)), last: 1'b0, no_gap: 1'b1});
         pushed_total++;
      end
      push(CH_SPACE);
   endtask

   function automatic logic stray_last();
      return $urandom_range(0, 49) == 0;
   endfunction

   function automatic logic [7:0] word_byte(input bit first);
      logic [7:0] c;
      do begin
         c = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(8'h61, 8'h7A))
                                        : 8'($urandom_range(1, 255));
      end while (c == CH_NUL || is_delim(c) || (first && c == CH_QUOTE));
      return c;
   endfunction

   function automatic logic [7:0] quoted_byte();
      if ($urandom_range(0, 6) != 0) return 8'($urandom_range(8'h20, 8'h7E));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_separators();
      int n;
      int k;
      n = (delim_count_q > 3'd6) ? DELIM_SLOTS : int'(delim_count_q);
      for (k = $urandom_range(1, 3); k > 0; k--) begin
         if (n == 0) push(CH_NUL);
         else push(delim_set[$urandom_range(0, n - 1)], stray_last());
      end
   endtask

   // mostly well-formed words and quoted strings, some noise and broken endings
   task automatic push_text(input int count);
      int stop;
      int len;
      int r;
      int i;
      stop = pushed_total + count;
      while (pushed_total < stop) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            push(word_byte(1'b1), stray_last());
            for (i = 1; i < len; i++) push(word_byte(1'b0), stray_last());
            push_separators();
         end else if (r < 72) begin
            push(CH_QUOTE, stray_last());
            len = $urandom_range(0, 10);
            for (i = 0; i < len; i++) begin
               if ($urandom_range(0, 6) == 0) begin
                  push(CH_BSLASH);
                  push(8'($urandom_range(0, 255)), stray_last());
               end else begin
                  push(quoted_byte(), stray_last());
               end
            end
            r = $urandom_range(0, 99);
            if (r < 80) push(CH_QUOTE, stray_last());
            else if (r < 88) push(CH_LF);
            else if (r < 94) push(CH_NUL);
            else push(word_byte(1'b0), 1'b1);
            push_separators();
         end else if (r < 84) begin
            for (i = $urandom_range(1, 6); i > 0; i--)
               push(8'($urandom_range(0, 255)), stray_last());
         end else if (r < 92) begin
            push(CH_NUL);
         end else begin
            push(word_byte(1'b0), 1'b1);
         end
      end
   endtask

   task automatic set_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                          input logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_DELIM_COUNT: delim_count_q = val[2:0];
         REG_DELIM_A, REG_DELIM_B, REG_DELIM_C,
         REG_DELIM_D, REG_DELIM_E, REG_DELIM_F: delim_set[idx - REG_DELIM_A] = val;
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [2:0] count, input logic [7:0] a, b, c, d, e, f);
      // upper bits of the count write are don't-care
      set_reg(REG_DELIM_COUNT, {5'($urandom_range(0, 31)), count});
      set_reg(REG_DELIM_A, a);
      set_reg(REG_DELIM_B, b);
      set_reg(REG_DELIM_C, c);
      set_reg(REG_DELIM_D, d);
      set_reg(REG_DELIM_E, e);
      set_reg(REG_DELIM_F, f);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [7:0] random_delim();
      logic [7:0] usual [10] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF, 8'h2C, 8'h3B,
                                 8'h3A, 8'h7C, CH_QUOTE, CH_NUL};
      if ($urandom_range(0, 1) != 0) return usual[$urandom_range(0, 9)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic wait_idle();
      while (checked_total != pushed_total) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < RUN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int p;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset delimiters: space, tab, CR, LF
      push_string(" ab\t\"x\\\"y\"\"q\nz");
      push(CH_NUL);
      push(8'hFF, 1'b1);
      push(CH_QUOTE, 1'b1);
      push(CH_SPACE, 1'b1);
      push(8'h80);
      push_string("\r\"\\\nm");
      push("n", 1'b1);
      push_long_token();
      push_text(150);
      wait_idle();

      // no delimiters at all: only zero, last and a closing quote end a token
      apply_config(3'd0, random_delim(), random_delim(), random_delim(),
                   random_delim(), random_delim(), random_delim());
      push_string(" a b");
      push(CH_NUL);
      push_string("\"c\n\"");
      push(CH_NUL);
      push_text(150);
      wait_idle();

      // full set with quote, zero and 0xFF as delimiters
      apply_config(3'd6, CH_QUOTE, CH_NUL, 8'hFF, 8'h2C, CH_SPACE, CH_LF);
      push_string("\"a\"");
      push(8'hFF);
      push_string("b,\\\"c");
      push(CH_NUL);
      push_text(150);
      wait_idle();

      // count above six behaves as six
      apply_config(3'd7, 8'h3B, CH_SPACE, CH_TAB, CH_LF, 8'h3A, 8'h7C);
      push_string("a;b:\"c|d\" e\tf\ng");
      push_text(150);
      wait_idle();

      // LF outside the active set: it no longer closes a quoted token
      apply_config(3'd3, CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_NUL, CH_NUL);
      push_string("\"a\nb\\\"c\" x\ny ");
      push_text(150);
      wait_idle();

      for (p = 0; p < 3; p++) begin
         apply_config(3'($urandom_range(0, 7)), random_delim(), random_delim(), random_delim(),
                      random_delim(), random_delim(), random_delim());
         push_text(120);
         wait_idle();
      end

      // write to the unused index must not disturb anything
      set_reg(REG_NONE, 8'($urandom_range(0, 255)));
      apply_config(RST_DELIM_COUNT, RST_DELIM_A, RST_DELIM_B, RST_DELIM_C,
                   RST_DELIM_D, RST_DELIM_E, RST_DELIM_F);
      push_text(150);
      wait_idle();

      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/dqt_pkg.sv
rtl/core/dqt_classify.sv
rtl/core/delimited_quoted_tokenizer.sv
tb/delimited_quoted_tokenizer_test.sv
